[src/sorted_array_binary_search_assert.svh]
// Assertion macros for the binary search block
`ifndef SORTED_ARRAY_BINARY_SEARCH_ASSERT_SVH
`define SORTED_ARRAY_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define SABS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SABS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sabs_pkg.sv]
package sabs_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int LEN_W = 11;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE
  } state_t;

endpackage

[src/sabs_if.sv]
interface sabs_in_if
  import sabs_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic        [IDX_W-1:0] elem_index;
  logic signed [VAL_W-1:0] elem_value;
  logic signed [VAL_W-1:0] key;

  modport source (output valid, func, elem_index, elem_value, key, input ready);
  modport sink   (input valid, func, elem_index, elem_value, key, output ready);
endinterface

interface sabs_out_if
  import sabs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface sabs_cfg_if
  import sabs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] used_length;

  modport source (output valid, used_length, input ready);
  modport sink   (input valid, used_length, output ready);
endinterface

[src/sorted_array_binary_search.sv]
// Write word: taken when idle, no result.
// Search word: a setup state, then one probe per cycle from the store RAM while the
//   result register is free; result registered after P probes,
//   P <= ceil(log2(used_length + 1)). Input held off during a search.
// Reset clears control and used_length; store contents stay undefined.
module sorted_array_binary_search
  import sabs_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  sabs_in_if.sink    item,
  sabs_out_if.source result,
  sabs_cfg_if.sink   cfg
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW = $clog2(STORE_DEPTH + 1);

  logic [LEN_W-1:0] used_length;
  logic [LW-1:0]    used_len;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      used_length <= cfg.used_length;
    end
  end

  assign used_len = (32'(used_length) > 32'(STORE_DEPTH)) ? LW'(STORE_DEPTH)
                                                          : LW'(used_length);

  sabs_engine #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .result   (result),
    .used_len (used_len),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  sabs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

[src/sabs_ram.sv]
module sabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sabs_engine.sv]
module sabs_engine
  import sabs_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  sabs_in_if.sink                                                  item,
  sabs_out_if.source                                               result,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]                         used_len,
  output logic                                                     mem_we,
  output logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] mem_waddr,
  output logic [VAL_W-1:0]                                         mem_wdata,
  output logic                                                     mem_re,
  output logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] mem_raddr,
  input  logic [VAL_W-1:0]                                         mem_rdata
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW = $clog2(STORE_DEPTH + 1);

  state_t                  state, state_next;
  logic [LW-1:0]           lo, lo_next;
  logic [LW-1:0]           hi, hi_next;
  logic [LW-1:0]           probe, probe_next;
  logic signed [VAL_W-1:0] key_q;
  logic                    out_valid;
  logic                    out_found;
  logic [IDX_W-1:0]        out_pos;

  logic          accept;
  logic          out_free;
  logic          hit;
  logic          less;
  logic [LW-1:0] lo_upd, hi_upd;
  logic [LW-1:0] win_lo, win_hi;
  logic [LW-1:0] mid_n;
  logic          emit;
  logic          emit_found;

  assign item.ready      = (state == ST_IDLE);
  assign accept          = item.valid && item.ready;
  assign out_free        = !out_valid || result.ready;
  assign result.valid    = out_valid;
  assign result.found    = out_found;
  assign result.position = out_pos;

  assign mem_we    = accept && (item.func == FUNC_WRITE) &&
                     (32'(item.elem_index) < 32'(STORE_DEPTH));
  assign mem_waddr = AW'(item.elem_index);
  assign mem_wdata = item.elem_value;
  assign mem_raddr = mid_n[AW-1:0];

  assign hit    = (mem_rdata == key_q);
  assign less   = key_q < $signed(mem_rdata);
  assign lo_upd = less ? lo : probe + LW'(1);
  assign hi_upd = less ? probe : hi;
  assign win_lo = (state == ST_PROBE) ? lo_upd : lo;
  assign win_hi = (state == ST_PROBE) ? hi_upd : hi;
  assign mid_n  = win_lo + ((win_hi - win_lo) >> 1);

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    probe_next = probe;
    mem_re     = 1'b0;
    emit       = 1'b0;
    emit_found = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && item.func == FUNC_SEARCH) begin
          lo_next    = '0;
          hi_next    = used_len;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (hi > lo) begin
          mem_re     = 1'b1;
          probe_next = mid_n;
          state_next = ST_PROBE;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PROBE: begin
        if (out_free) begin
          if (hit) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            state_next = ST_IDLE;
          end else begin
            lo_next = lo_upd;
            hi_next = hi_upd;
            if (hi_upd > lo_upd) begin
              mem_re     = 1'b1;
              probe_next = mid_n;
            end else begin
              emit       = 1'b1;
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lo        <= '0;
      hi        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      lo    <= lo_next;
      hi    <= hi_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe <= probe_next;
    if (accept) begin
      key_q <= item.key;
    end
    if (emit) begin
      out_found <= emit_found;
      out_pos   <= emit_found ? IDX_W'(probe) : '0;
    end
  end

endmodule

[src/sabs_checker.sv]
`include "sorted_array_binary_search_assert.svh"

module sabs_checker
  import sabs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [IDX_W-1:0] out_position,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  `SABS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_position), "result word dropped or changed while stalled")
  `SABS_ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_position == '0, "miss reported with non-zero position")
  `SABS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")
  `SABS_ASSERT_NEXT(a_write_silent, in_acc && in_func == FUNC_WRITE, !$rose(out_valid), "write word produced a result")
  `SABS_ASSERT_NEXT(a_search_busy, in_acc && in_func == FUNC_SEARCH, !in_ready, "input taken during a search")

endmodule

bind sorted_array_binary_search sabs_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .in_func     (item.func),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_found   (result.found),
  .out_position(result.position),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready)
);

[tb/tb_sorted_array_binary_search.sv]
module tb_sorted_array_binary_search;
  import sabs_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int SETTLE    = 16;
  localparam int LIMIT     = 400000;
  localparam int DIR_ROWS  = 24;
  localparam int MAX_SHOWN = 10;

  localparam logic [VAL_W-1:0] V_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] V_MAX = 32'h7fff_ffff;

  typedef enum logic {ROW_ITEM, ROW_LENGTH} row_kind_t;
  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} stall_mode_t;

  typedef struct packed {
    logic                    func;
    logic        [IDX_W-1:0] elem_index;
    logic signed [VAL_W-1:0] elem_value;
    logic signed [VAL_W-1:0] key;
  } item_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_hit_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic             typed;
    logic             hit_found;
    logic [IDX_W-1:0] hit_pos;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         32'd0,         11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd0,    V_MIN,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd1,    -32'sd1000,    32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd2,    -32'sd1,       32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd3,    32'd0,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd4,    32'd1,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd5,    32'd5,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd6,    32'd5,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd7,    V_MAX,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd1023, -32'sd1,       32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_LENGTH, FUNC_WRITE,  10'd0,    32'd0,         32'd0,         11'd8, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         V_MIN,         11'd0, 1'b1, 1'b1, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         V_MAX,         11'd0, 1'b1, 1'b1, 10'd7},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         32'd5,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         32'd2,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         -32'sd2,       11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_LENGTH, FUNC_WRITE,  10'd0,    32'd0,         32'd0,         11'd1, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         V_MIN,         11'd0, 1'b1, 1'b1, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         V_MAX,         11'd0, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_WRITE,  10'd2,    V_MAX,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_LENGTH, FUNC_WRITE,  10'd0,    32'd0,         32'd0,         11'd8, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         -32'sd1,       11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         V_MAX,         11'd0, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM,   FUNC_SEARCH, 10'd0,    32'd0,         32'd0,         11'd0, 1'b0, 1'b0, 10'd0}
  };

  localparam logic [LEN_W-1:0] FULL_LENS [8] = '{
    11'd1024, 11'd2047, 11'd0, 11'd1, 11'd2, 11'd1025, 11'd0, 11'd1024
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  sabs_in_if  in_ch ();
  sabs_out_if out_ch ();
  sabs_cfg_if len_ch ();

  sorted_array_binary_search #(
    .STORE_DEPTH(DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (len_ch)
  );

  logic signed [VAL_W-1:0] held_values [DEPTH];
  bit                      stored      [DEPTH];
  logic        [LEN_W-1:0] window_len;
  search_hit_t             hits_due [$];
  int                      err_count;
  int                      burst_left;
  int                      cycles;

  function automatic search_hit_t locate_key(input logic signed [VAL_W-1:0] k);
    int          lo;
    int          hi;
    int          mid;
    search_hit_t h;
    h  = '0;
    lo = 0;
    hi = (window_len > DEPTH) ? DEPTH : int'(window_len);
    while (hi > lo && !h.found) begin
      mid = lo + (hi - lo) / 2;
      if (held_values[mid] == k) begin
        h.found    = 1'b1;
        h.position = mid[IDX_W-1:0];
      end else if (k < held_values[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return h;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < DEPTH && stored[n]) n++;
    return n;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_key();
    int                      span;
    int                      r;
    logic signed [VAL_W-1:0] v;
    span = (window_len > DEPTH) ? DEPTH : int'(window_len);
    if (span == 0) return $urandom;
    v = held_values[$urandom_range(0, span - 1)];
    r = $urandom_range(0, 9);
    if (r < 5) return v;
    if (r == 5) return v + 1;
    if (r == 6) return v - 1;
    return $urandom;
  endfunction

  task automatic send_word(input item_word_t w, input logic typed, input search_hit_t typed_hit);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= w.func;
    in_ch.elem_index <= w.elem_index;
    in_ch.elem_value <= w.elem_value;
    in_ch.key        <= w.key;
    do @(posedge clk); while (!in_ch.ready);
    if (w.func == FUNC_SEARCH) begin
      hits_due.push_back(typed ? typed_hit : locate_key(w.key));
    end else begin
      held_values[w.elem_index] = w.elem_value;
      stored[w.elem_index]      = 1'b1;
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
    end
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    in_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    len_ch.valid       <= 1'b1;
    len_ch.used_length <= len;
    do @(posedge clk); while (!len_ch.ready);
    len_ch.valid <= 1'b0;
    window_len = len;
  endtask

  task automatic run_mix(input int n);
    item_word_t w;
    int         pfx;
    repeat (n) begin
      pfx          = written_prefix();
      w.elem_index = IDX_W'($urandom);
      w.elem_value = $urandom;
      w.key        = $urandom;
      if ($urandom_range(0, 9) == 0 && pfx > 0) begin
        w.func       = FUNC_WRITE;
        w.elem_index = IDX_W'($urandom_range(0, pfx - 1));
      end else begin
        w.func = FUNC_SEARCH;
        w.key  = pick_key();
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // receiver: hold ready in runs of open, half and sparse acceptance
  initial begin
    stall_mode_t mode;
    int          left;
    out_ch.ready <= 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 2));
        left = $urandom_range(32, 200);
      end
      left--;
      case (mode)
        RX_OPEN: out_ch.ready <= 1'b1;
        RX_HALF: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    search_hit_t want;
    search_hit_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.found    = out_ch.found;
      got.position = out_ch.position;
      if (hits_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("unexpected result word: found=%0b position=%0d", got.found, got.position);
      end else begin
        want = hits_due.pop_front();
        if (got.found !== want.found || got.position !== want.position) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("result mismatch: found=%0b position=%0d, wanted found=%0b position=%0d",
                     got.found, got.position, want.found, want.position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    item_word_t       w;
    logic [LEN_W-1:0] len;
    longint           fill_acc;
    int               next_fill;
    int               n;
    int               pfx;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_WRITE;
    in_ch.elem_index   <= '0;
    in_ch.elem_value   <= '0;
    in_ch.key          <= '0;
    len_ch.valid       <= 1'b0;
    len_ch.used_length <= '0;
    window_len = '0;
    err_count  = 0;
    cycles     = 0;
    burst_left = $urandom_range(1, 16);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_LENGTH) begin
        set_length(DIRECTED[i].len);
      end else begin
        w.func       = DIRECTED[i].func;
        w.elem_index = DIRECTED[i].idx;
        w.elem_value = DIRECTED[i].value;
        w.key        = DIRECTED[i].key;
        send_word(w, DIRECTED[i].typed, {DIRECTED[i].hit_found, DIRECTED[i].hit_pos});
      end
    end

    // fill the store in ascending order, searching the written prefix between chunks
    next_fill = 0;
    fill_acc  = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20));
    while (next_fill < DEPTH) begin
      n = $urandom_range(48, 160);
      while (n > 0 && next_fill < DEPTH) begin
        w.func       = FUNC_WRITE;
        w.elem_index = next_fill[IDX_W-1:0];
        w.elem_value = fill_acc[VAL_W-1:0];
        w.key        = $urandom;
        send_word(w, 1'b0, '0);
        if ($urandom_range(0, 7) != 0) fill_acc += longint'($urandom_range(1, 1 << 23));
        if (fill_acc > 64'sd2147483647) fill_acc = 64'sd2147483647;
        next_fill++;
        n--;
      end
      pfx = written_prefix();
      len = ($urandom_range(0, 1) == 0) ? LEN_W'(pfx) : LEN_W'($urandom_range(0, pfx));
      set_length(len);
      run_mix(10);
    end

    for (int p = 0; p < 8; p++) begin
      len = (p == 6) ? LEN_W'($urandom_range(3, 1023)) : FULL_LENS[p];
      set_length(len);
      run_mix(12);
    end

    in_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && hits_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
